FILE: hdl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

	// defaults for the top-level parameters
	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;

	// fixed field widths on the channels
	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int ERR_W   = 2;
	localparam int COUNT_W = 5;

	// commands
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

	// per-cycle operation broadcast to every cell
	typedef logic [1:0] cell_op_t;

	localparam cell_op_t CELL_HOLD = 2'd0; // keep contents
	localparam cell_op_t CELL_ROT  = 2'd1; // take right neighbor, last takes cell 0
	localparam cell_op_t CELL_SHR  = 2'd2; // take left neighbor, cell 0 takes word
	localparam cell_op_t CELL_LOAD = 2'd3; // cell at index == count takes word

endpackage

FILE: hdl/bdq_in_if.sv
`timescale 1ns / 1ps

interface bdq_in_if;
	logic                       valid;
	logic                       ready;
	logic [bdq_pkg::CMD_W-1:0]   command;
	logic [bdq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

FILE: hdl/bdq_out_if.sv
`timescale 1ns / 1ps

interface bdq_out_if;
	logic                       valid;
	logic                       ready;
	logic [bdq_pkg::VALUE_W-1:0] popped_value;
	logic                       found;
	logic [bdq_pkg::ERR_W-1:0]   error_code;
	logic [bdq_pkg::COUNT_W-1:0] entry_count;

	modport source (output valid, output popped_value, output found, output error_code,
		output entry_count, input ready);
	modport sink   (input valid, input popped_value, input found, input error_code,
		input entry_count, output ready);
endinterface

FILE: hdl/bdq_cell.sv
`timescale 1ns / 1ps

module bdq_cell #(
	parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF,
	parameter int CNT_W      = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  bdq_pkg::cell_op_t     op,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [CNT_W-1:0]      count,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_back;

	// this cell is the first free slot behind the back entry
	assign at_back = (count == CNT_W'(INDEX));

	always_ff @(posedge clk) begin
		case (op)
			bdq_pkg::CELL_ROT: begin
				data_q <= right_data;
			end
			bdq_pkg::CELL_SHR: begin
				data_q <= left_data;
			end
			bdq_pkg::CELL_LOAD: begin
				if (at_back) begin
					data_q <= word;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

FILE: hdl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bdq_in_if.sink                req,
	bdq_out_if.source             rsp,
	input  logic [DATA_WIDTH-1:0] head_data,
	output bdq_pkg::cell_op_t     cell_op,
	output logic [DATA_WIDTH-1:0] cell_word,
	output logic [CNT_W-1:0]      count
);

	localparam int STEP_W = $clog2(DEPTH);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_ROT  = 1'b1;

	logic [0:0]       state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic             res_valid_q;

	// working registers of a rotation pass
	logic [bdq_pkg::CMD_W-1:0] cmd_q;
	logic [DATA_WIDTH-1:0]     word_q;
	logic [DATA_WIDTH-1:0]     pop_q, pop_d;
	logic                      hit_q, hit_d;

	// result register
	logic [DATA_WIDTH-1:0]     res_pop_q, res_pop_d;
	logic                      res_found_q, res_found_d;
	logic [bdq_pkg::ERR_W-1:0] res_err_q, res_err_d;
	logic [CNT_W-1:0]          res_cnt_q;
	logic                      res_load;

	logic        fire, full, empty, last_step, in_range;
	logic [63:0] value_ext;
	logic [63:0] pop_ext;
	logic [31:0] cnt_ext;
	logic [DATA_WIDTH-1:0] word_in;
	logic [CNT_W-1:0]      step_ext;

	assign value_ext = 64'(req.value);
	assign word_in   = value_ext[DATA_WIDTH-1:0];

	assign req.ready = (state_q == ST_IDLE) && (!res_valid_q || rsp.ready);
	assign fire      = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign last_step = (step_q == STEP_W'(DEPTH - 1));
	assign step_ext  = CNT_W'(step_q);
	assign in_range  = (step_ext < count_q);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		step_d      = step_q;
		cell_op     = bdq_pkg::CELL_HOLD;
		cell_word   = word_in;
		pop_d       = pop_q;
		hit_d       = hit_q;
		res_load    = 1'b0;
		res_pop_d   = '0;
		res_found_d = 1'b0;
		res_err_d   = bdq_pkg::ERR_OK;
		case (state_q)
			ST_IDLE: begin
				pop_d = '0;
				hit_d = 1'b0;
				if (fire) begin
					case (req.command)
						bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
							res_load = 1'b1;
							if (full) begin
								res_err_d = bdq_pkg::ERR_FULL;
							end else begin
								count_d = count_q + 1'b1;
								cell_op = (req.command == bdq_pkg::CMD_PUSH_FRONT) ?
									bdq_pkg::CELL_SHR : bdq_pkg::CELL_LOAD;
							end
						end
						bdq_pkg::CMD_POP_FRONT: begin
							res_load = 1'b1;
							if (empty) begin
								res_err_d = bdq_pkg::ERR_EMPTY;
							end else begin
								res_pop_d = head_data;
								count_d   = count_q - 1'b1;
								cell_op   = bdq_pkg::CELL_ROT;
							end
						end
						bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_SEARCH: begin
							if (empty) begin
								res_load = 1'b1;
								if (req.command == bdq_pkg::CMD_POP_BACK) begin
									res_err_d = bdq_pkg::ERR_EMPTY;
								end
							end else begin
								state_d = ST_ROT;
								step_d  = '0;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_ROT: begin
				// full circle: entry k sits in cell 0 at step k
				cell_op = bdq_pkg::CELL_ROT;
				step_d  = step_q + 1'b1;
				if (cmd_q == bdq_pkg::CMD_POP_BACK && step_ext == count_q - 1'b1) begin
					pop_d = head_data;
				end
				if (cmd_q == bdq_pkg::CMD_SEARCH && in_range && head_data == word_q) begin
					hit_d = 1'b1;
				end
				if (last_step) begin
					state_d     = ST_IDLE;
					res_load    = 1'b1;
					res_pop_d   = pop_d;
					res_found_d = hit_d;
					if (cmd_q == bdq_pkg::CMD_POP_BACK) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q  <= step_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pop_q <= pop_d;
		hit_q <= hit_d;
		if (fire) begin
			cmd_q  <= req.command;
			word_q <= word_in;
		end
		if (res_load) begin
			res_pop_q   <= res_pop_d;
			res_found_q <= res_found_d;
			res_err_q   <= res_err_d;
			res_cnt_q   <= count_d;
		end
	end

	assign pop_ext = 64'(res_pop_q);
	assign cnt_ext = 32'(res_cnt_q);

	assign rsp.valid        = res_valid_q;
	assign rsp.popped_value = pop_ext[bdq_pkg::VALUE_W-1:0];
	assign rsp.found        = res_found_q;
	assign rsp.error_code   = res_err_q;
	assign rsp.entry_count  = cnt_ext[bdq_pkg::COUNT_W-1:0];
	assign count            = count_q;

endmodule

FILE: hdl/bounded_deque_with_search.sv
`timescale 1ns / 1ps

// Bounded double-ended queue with search. The entries live in a row of DEPTH
// cells, front entry always in cell 0 and the back entry in cell count-1.
// Push front shifts the row right and loads cell 0; push back loads the first
// free cell; pop front reads cell 0 and rotates the row left. These have a
// valid result in the cycle after the request transfers. Pop back and search
// rotate the whole row through a full circle, one position a cycle, looking at
// cell 0 as each entry passes; their result loads at the last rotation step,
// set by the length of the cell row. One request is in flight at a time: a new
// request transfers once the result register is empty or being drained in the
// same cycle. Pushing into a full queue returns error 1 and popping an empty
// one error 2, with the queue left as it was; unused command codes return the
// count and nothing else.

module bounded_deque_with_search #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_in_if.sink    req,
	bdq_out_if.source rsp
);

	// count has to reach DEPTH itself
	localparam int CNT_W = $clog2(DEPTH + 1);

	bdq_pkg::cell_op_t     cell_op;
	logic [DATA_WIDTH-1:0] cell_word;
	logic [CNT_W-1:0]      count;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	// sequencer: count, rotation step counter and the result register
	bdq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.head_data (cell_data[0]),
		.cell_op   (cell_op),
		.cell_word (cell_word),
		.count     (count)
	);

	// the cell row; rotation closes the ring from the last cell back to cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int RIGHT = (i + 1) % DEPTH;
		logic [DATA_WIDTH-1:0] left_data;

		if (i == 0) begin : g_head
			assign left_data = cell_word;
		end else begin : g_body
			assign left_data = cell_data[i-1];
		end

		bdq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.word       (cell_word),
			.left_data  (left_data),
			.right_data (cell_data[RIGHT]),
			.count      (count),
			.data       (cell_data[i])
		);
	end

endmodule
